FILE: hdl/signed_integer_divider_defines.svh
// Assertion macros for the signed integer divider checker
`ifndef SIGNED_INTEGER_DIVIDER_DEFINES_SVH
`define SIGNED_INTEGER_DIVIDER_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset
`define SID_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset
`define SID_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/sid_pkg.sv
// Shared types and constants of the signed integer divider
`timescale 1ns / 1ps

package sid_pkg;

    localparam int DATA_W = 32;
    localparam int REM_W  = 31;
    localparam int CNT_W  = $clog2(DATA_W);

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_DIV0 = 2'd1;
    localparam logic [1:0] STATUS_OVF  = 2'd2;

    localparam logic [DATA_W-1:0] QUOT_SAT = {1'b0, {(DATA_W-1){1'b1}}};

    typedef struct packed {
        logic signed [DATA_W-1:0] dividend;
        logic signed [DATA_W-1:0] divisor_value;
    } operand_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] quotient;
        logic        [REM_W-1:0]  remainder;
        logic        [1:0]        status;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_RUN    = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

endpackage

FILE: hdl/signed_integer_divider.sv
// Top level of the signed integer divider
//
//   channel   direction  handshake                      word
//   operand   in         operand_valid / operand_ready  dividend, divisor_value
//   result    out        result_valid / result_ready    quotient, remainder, status
//
// One word at a time: an accept step, the shift-subtract loop, a done step and a
// finish step per word; a zero divisor skips the loop.
// The shift-subtract loop in sid_divcore produces one quotient bit a cycle.
// A new operand is taken while a finished result waits in the output register.
// A stalled result holds the finish step until the output register frees.
// Reset clears the control state; no clearing pass.
`timescale 1ns / 1ps

module signed_integer_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              operand_valid,
    output logic              operand_ready,
    input  sid_pkg::operand_t operand,
    output logic              result_valid,
    input  logic              result_ready,
    output sid_pkg::result_t  result
);

    sid_pkg::state_t            state_reg, state_next;
    logic                       negate_reg, negate_next;
    logic                       div_zero_reg, div_zero_next;
    logic                       result_valid_reg, result_valid_next;
    sid_pkg::result_t           result_reg, result_next;
    sid_pkg::result_t           fixed;
    logic [sid_pkg::DATA_W-1:0] dividend_mag;
    logic [sid_pkg::DATA_W-1:0] divisor_mag;
    logic [sid_pkg::DATA_W-1:0] quotient_mag;
    logic [sid_pkg::DATA_W-1:0] remainder_mag;
    logic                       accept;
    logic                       start;
    logic                       done;
    logic                       load;

    assign operand_ready = (state_reg == sid_pkg::ST_IDLE);
    assign accept        = operand_valid && operand_ready;

    always_comb
    begin
        dividend_mag = operand.dividend[sid_pkg::DATA_W-1] ?
                       ~operand.dividend + 1'b1 : operand.dividend;
        divisor_mag  = operand.divisor_value[sid_pkg::DATA_W-1] ?
                       ~operand.divisor_value + 1'b1 : operand.divisor_value;
    end

    assign start = accept && (divisor_mag != '0);
    assign load  = (state_reg == sid_pkg::ST_FINISH) && (!result_valid_reg || result_ready);

    sid_divcore u_divcore
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .dividend_mag  (dividend_mag),
        .divisor_mag   (divisor_mag),
        .done          (done),
        .quotient_mag  (quotient_mag),
        .remainder_mag (remainder_mag)
    );

    sid_fix u_fix
    (
        .quotient_mag  (quotient_mag),
        .remainder_mag (remainder_mag),
        .negate        (negate_reg),
        .div_zero      (div_zero_reg),
        .result        (fixed)
    );

    always_comb
    begin
        state_next        = state_reg;
        negate_next       = negate_reg;
        div_zero_next     = div_zero_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            sid_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    negate_next   = operand.dividend[sid_pkg::DATA_W-1] ^
                                    operand.divisor_value[sid_pkg::DATA_W-1];
                    div_zero_next = (divisor_mag == '0);
                    state_next    = (divisor_mag == '0) ? sid_pkg::ST_FINISH : sid_pkg::ST_RUN;
                end
            end
            sid_pkg::ST_RUN:
            begin
                if (done)
                begin
                    state_next = sid_pkg::ST_FINISH;
                end
            end
            sid_pkg::ST_FINISH:
            begin
                if (load)
                begin
                    result_next       = fixed;
                    result_valid_next = 1'b1;
                    state_next        = sid_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sid_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= sid_pkg::ST_IDLE;
            result_valid_reg <= 1'b0;
            negate_reg       <= 1'b0;
            div_zero_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            negate_reg       <= negate_next;
            div_zero_reg     <= div_zero_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: hdl/sid_divcore.sv
// Restoring shift-subtract divider on magnitudes, one quotient bit per cycle
`timescale 1ns / 1ps

module sid_divcore
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [sid_pkg::DATA_W-1:0] dividend_mag,
    input  logic [sid_pkg::DATA_W-1:0] divisor_mag,
    output logic                       done,
    output logic [sid_pkg::DATA_W-1:0] quotient_mag,
    output logic [sid_pkg::DATA_W-1:0] remainder_mag
);

    localparam logic [sid_pkg::CNT_W-1:0] LAST_STEP = sid_pkg::CNT_W'(sid_pkg::DATA_W - 1);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [sid_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [sid_pkg::DATA_W-1:0] shift_reg, shift_next;
    logic [sid_pkg::DATA_W-1:0] rem_reg, rem_next;
    logic [sid_pkg::DATA_W-1:0] div_reg, div_next;
    logic [sid_pkg::DATA_W:0]   partial;
    logic [sid_pkg::DATA_W:0]   trial;
    logic                       qbit;

    always_comb
    begin
        partial = {rem_reg, shift_reg[sid_pkg::DATA_W-1]};
        trial   = partial - {1'b0, div_reg};
        qbit    = !trial[sid_pkg::DATA_W];

        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;

        if (start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            shift_next = dividend_mag;
            rem_next   = '0;
            div_next   = divisor_mag;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, keep the difference when it fits
            shift_next = {shift_reg[sid_pkg::DATA_W-2:0], qbit};
            rem_next   = qbit ? trial[sid_pkg::DATA_W-1:0] : partial[sid_pkg::DATA_W-1:0];
            count_next = count_reg + 1'b1;
            if (count_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
    end

    assign done          = done_reg;
    assign quotient_mag  = shift_reg;
    assign remainder_mag = rem_reg;

endmodule

FILE: hdl/sid_fix.sv
// Sign correction, saturation and status of a finished division
`timescale 1ns / 1ps

module sid_fix
(
    input  logic [sid_pkg::DATA_W-1:0] quotient_mag,
    input  logic [sid_pkg::DATA_W-1:0] remainder_mag,
    input  logic                       negate,
    input  logic                       div_zero,
    output sid_pkg::result_t           result
);

    always_comb
    begin
        result.remainder = remainder_mag[sid_pkg::REM_W-1:0];
        result.status    = sid_pkg::STATUS_OK;
        priority if (div_zero)
        begin
            result.quotient  = '0;
            result.remainder = '0;
            result.status    = sid_pkg::STATUS_DIV0;
        end
        else if (negate)
        begin
            result.quotient = ~quotient_mag + 1'b1;
        end
        else if (quotient_mag[sid_pkg::DATA_W-1])
        begin
            // clamp the one positive quotient that does not fit
            result.quotient = sid_pkg::QUOT_SAT;
            result.status   = sid_pkg::STATUS_OVF;
        end
        else
        begin
            result.quotient = quotient_mag;
        end
    end

endmodule

FILE: hdl/sid_checker.sv
// Port-level assertions of the signed integer divider and their binding
`timescale 1ns / 1ps
`include "signed_integer_divider_defines.svh"

module sid_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              operand_valid,
    input logic              operand_ready,
    input sid_pkg::operand_t operand,
    input logic              result_valid,
    input logic              result_ready,
    input sid_pkg::result_t  result
);

    `SID_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "result word dropped or changed while stalled")
    `SID_ASSERT_NEXT(a_one_at_a_time, operand_valid && operand_ready, !operand_ready, "operand taken while a division is in progress")
    `SID_ASSERT_NOW(a_status_code, result_valid, result.status == sid_pkg::STATUS_OK || result.status == sid_pkg::STATUS_DIV0 || result.status == sid_pkg::STATUS_OVF, "unknown status code")
    `SID_ASSERT_NOW(a_div0_zeros, result_valid && result.status == sid_pkg::STATUS_DIV0, result.quotient == '0 && result.remainder == '0, "zero divisor result not cleared")
    `SID_ASSERT_NOW(a_ovf_sat, result_valid && result.status == sid_pkg::STATUS_OVF, result.quotient == sid_pkg::QUOT_SAT && result.remainder == '0, "overflow result not saturated")

endmodule

bind signed_integer_divider sid_checker u_sid_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .operand_valid (operand_valid),
    .operand_ready (operand_ready),
    .operand       (operand),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result        (result)
);
